[hdl/rit_pkg.sv]
package rit_pkg;

   localparam int CH_W       = 8;
   localparam int RADIX_W    = 6;
   localparam int DIGIT_W    = 6;
   localparam int VALUE_W    = 64;
   localparam int END_W      = 16;
   localparam int RSP_RAW_W  = VALUE_W + 1 + END_W + 1;
   localparam int RSP_DATA_W = ((RSP_RAW_W + 7) / 8) * 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = RADIX_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED = 1'd1;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
   localparam logic [RADIX_W-1:0] BASE_ONE    = 6'd1;
   localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
   localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
   localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
   localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
   localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;
   localparam logic [DIGIT_W-1:0] DIGIT_NONE  = 6'd36;

   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_0     = 8'h30;
   localparam logic [CH_W-1:0] CH_9     = 8'h39;
   localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
   localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
   localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;

   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic               signed_mode;
   } cfg_type;

   // value of a character as a digit, DIGIT_NONE when it is none
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
      logic [CH_W-1:0] t;
      t = '0;
      if (c >= CH_0 && c <= CH_9) begin
         t = c - CH_0;
         return t[DIGIT_W-1:0];
      end
      if (c >= CH_LO_A && c <= CH_LO_Z) begin
         t = c - CH_LO_A + 8'd10;
         return t[DIGIT_W-1:0];
      end
      if (c >= CH_UP_A && c <= CH_UP_Z) begin
         t = c - CH_UP_A + 8'd10;
         return t[DIGIT_W-1:0];
      end
      return DIGIT_NONE;
   endfunction

endpackage

[hdl/radix_integer_text_parser.sv]
// Streaming integer parser: one character per item on req_, at most one result per string
// on rsp_. Items go in at up to one per cycle unless held by an unread result (below); each
// character passes an input register and is then folded into the parse state (a base
// multiply-add on the accumulator) that feeds the result register. Only a character that
// produces a result waits, while an earlier result is still unread on rsp_.
// A string starts with tuser high on its first character; radix is sampled at that point
// and signed_mode when the result is formed. Write csr_ only between strings.
// rsp_tdata holds value in the low VALUE_BITS bits of its 64-bit field.
module radix_integer_text_parser import rit_pkg::*; #(
   parameter int VALUE_BITS  = 64,
   parameter int OFFSET_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CH_W-1:0]       req_tdata,  // ch
   input  logic                  req_tuser,  // first
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // value, overflowed, end_offset, bad_radix
);

   cfg_type         cfg_ff;
   logic            in_valid_ff;
   logic [CH_W-1:0] in_ch_ff;
   logic            in_first_ff;
   logic            item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix       <= RADIX_RESET;
         cfg_ff.signed_mode <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RADIX:  cfg_ff.radix       <= csr_wdata;
            CSR_SIGNED: cfg_ff.signed_mode <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_tready = !in_valid_ff || item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
         in_ch_ff    <= req_tdata;
         in_first_ff <= req_tuser;
      end
   end

   rit_parser #(.VALUE_BITS(VALUE_BITS), .OFFSET_BITS(OFFSET_BITS)) u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (in_valid_ff),
      .item_ch    (in_ch_ff),
      .item_first (in_first_ff),
      .item_ready (item_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hdl/rit_digit_unit.sv]
module rit_digit_unit import rit_pkg::*; #(
   parameter int VALUE_BITS = 64
) (
   input  logic [VALUE_BITS-1:0] acc,
   input  logic                  ovf,
   input  logic [RADIX_W-1:0]    base,
   input  logic [DIGIT_W-1:0]    digit,
   output logic [VALUE_BITS-1:0] acc_next,
   output logic                  ovf_next
);

   localparam int PW = VALUE_BITS + RADIX_W;

   logic [PW-1:0] prod;
   logic [PW-1:0] sum;
   logic          wrap;

   // acc*base+digit overflows exactly when any bit above VALUE_BITS is set
   assign prod = {{RADIX_W{1'b0}}, acc} * {{VALUE_BITS{1'b0}}, base};
   assign sum  = prod + PW'(digit);
   assign wrap = |sum[PW-1:VALUE_BITS];

   always_comb begin
      if (ovf) begin
         acc_next = acc;
         ovf_next = 1'b1;
      end else if (wrap) begin
         acc_next = '1;
         ovf_next = 1'b1;
      end else begin
         acc_next = sum[VALUE_BITS-1:0];
         ovf_next = 1'b0;
      end
   end

endmodule

[hdl/rit_parser.sv]
module rit_parser import rit_pkg::*; #(
   parameter int VALUE_BITS  = 64,
   parameter int OFFSET_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  item_valid,
   input  logic [CH_W-1:0]       item_ch,
   input  logic                  item_first,
   output logic                  item_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [2:0] {
      PH_WS, PH_START, PH_ZERO, PH_HEXPFX, PH_DIGITS, PH_DONE
   } phase_type;

   localparam int OB_EXT = (OFFSET_BITS > END_W) ? OFFSET_BITS : END_W;
   localparam logic [VALUE_BITS-1:0] VMAX = '1;
   localparam logic [VALUE_BITS-1:0] SMAX = VMAX >> 1;
   localparam logic [VALUE_BITS-1:0] SMIN = SMAX + 1'b1;

   phase_type              phase_ff, phase_in, cur_phase;
   logic                   minus_ff, minus_in, cur_minus;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in, cur_acc, acc_dig;
   logic                   ovf_ff, ovf_in, cur_ovf, ovf_dig;
   logic [RADIX_W-1:0]     base_ff, base_in, cur_base, dig_base;
   logic [OFFSET_BITS-1:0] cnt_ff, cnt_in, cur_cnt, cnt_inc;
   logic [OFFSET_BITS-1:0] dend_ff, dend_in, cur_dend;

   logic                   rsp_valid_ff;
   logic [VALUE_BITS-1:0]  out_value_ff, out_value_in;
   logic                   out_ovf_ff, out_ovf_in;
   logic [OFFSET_BITS-1:0] out_end_ff, out_end_in;
   logic                   out_bad_ff, out_bad_in;
   logic [OB_EXT-1:0]      out_end_ext;

   logic                   step, emit;
   logic                   radix_bad, is_ws, take;
   logic [DIGIT_W-1:0]     digit;
   logic [VALUE_BITS-1:0]  fin_value;
   logic                   fin_ovf;

   // only an item that produces a result waits for the result register
   assign step       = item_valid && (!emit || !rsp_valid_ff || rsp_tready);
   assign item_ready = step;

   // first=1 restarts from a clean state before the character is looked at
   always_comb begin
      cur_phase = item_first ? PH_WS : phase_ff;
      cur_minus = item_first ? 1'b0 : minus_ff;
      cur_acc   = item_first ? '0 : acc_ff;
      cur_ovf   = item_first ? 1'b0 : ovf_ff;
      cur_cnt   = item_first ? '0 : cnt_ff;
      cur_dend  = item_first ? '0 : dend_ff;
      cur_base  = item_first ? cfg.radix : base_ff;
   end

   assign radix_bad = (cfg.radix == BASE_ONE) || (cfg.radix > BASE_MAX);
   assign cnt_inc   = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
   assign digit     = digit_of(item_ch);
   assign is_ws     = (item_ch == CH_SPACE) || (item_ch >= CH_TAB && item_ch <= CH_CR);

   // base a digit is judged against on this character
   always_comb begin
      unique case (cur_phase)
         PH_WS, PH_START: dig_base = (cur_base == BASE_AUTO) ? BASE_DEC : cur_base;
         PH_ZERO:         dig_base = (cur_base == BASE_AUTO) ? BASE_OCT : cur_base;
         default:         dig_base = cur_base;
      endcase
   end

   assign take = (dig_base >= BASE_MIN) && (digit < dig_base);

   rit_digit_unit #(.VALUE_BITS(VALUE_BITS)) u_digit (
      .acc      (cur_acc),
      .ovf      (cur_ovf),
      .base     (dig_base),
      .digit    (digit),
      .acc_next (acc_dig),
      .ovf_next (ovf_dig)
   );

   always_comb begin
      fin_value = cur_acc;
      fin_ovf   = cur_ovf;
      if (!cfg.signed_mode) begin
         if (cur_minus) fin_value = VMAX;
      end else if (cur_minus) begin
         if (cur_acc > SMIN) begin
            fin_value = SMIN;
            fin_ovf   = 1'b1;
         end else begin
            fin_value = '0 - cur_acc;
         end
      end else if (cur_acc > SMAX) begin
         fin_value = SMAX;
         fin_ovf   = 1'b1;
      end
   end

   always_comb begin
      phase_in     = cur_phase;
      minus_in     = cur_minus;
      acc_in       = cur_acc;
      ovf_in       = cur_ovf;
      base_in      = cur_base;
      cnt_in       = cur_cnt;
      dend_in      = cur_dend;
      emit         = 1'b0;
      out_value_in = '0;
      out_ovf_in   = 1'b0;
      out_end_in   = '0;
      out_bad_in   = 1'b0;
      if (item_first && radix_bad) begin
         emit       = 1'b1;
         out_bad_in = 1'b1;
         phase_in   = PH_DONE;
      end else begin
         unique case (cur_phase)
            PH_WS, PH_START: begin
               if (cur_phase == PH_WS && is_ws) begin
                  cnt_in = cnt_inc;
               end else if (cur_phase == PH_WS &&
                            (item_ch == CH_PLUS || item_ch == CH_MINUS)) begin
                  minus_in = (item_ch == CH_MINUS);
                  cnt_in   = cnt_inc;
                  phase_in = PH_START;
               end else if (item_ch == CH_0 &&
                            (cur_base == BASE_AUTO || cur_base == BASE_HEX)) begin
                  cnt_in   = cnt_inc;
                  dend_in  = cnt_inc;
                  phase_in = PH_ZERO;
               end else if (take) begin
                  acc_in   = acc_dig;
                  ovf_in   = ovf_dig;
                  cnt_in   = cnt_inc;
                  dend_in  = cnt_inc;
                  base_in  = dig_base;
                  phase_in = PH_DIGITS;
               end else begin
                  // no digits at all
                  emit     = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            PH_ZERO, PH_HEXPFX, PH_DIGITS: begin
               if (cur_phase == PH_ZERO && (item_ch == CH_LO_X || item_ch == CH_UP_X)) begin
                  cnt_in   = cnt_inc;
                  base_in  = BASE_HEX;
                  phase_in = PH_HEXPFX;
               end else if (take) begin
                  acc_in   = acc_dig;
                  ovf_in   = ovf_dig;
                  cnt_in   = cnt_inc;
                  dend_in  = cnt_inc;
                  base_in  = dig_base;
                  phase_in = PH_DIGITS;
               end else begin
                  emit         = 1'b1;
                  out_value_in = fin_value;
                  out_ovf_in   = fin_ovf;
                  out_end_in   = cur_dend;
                  phase_in     = PH_DONE;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WS;
         minus_ff     <= 1'b0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         base_ff      <= BASE_DEC;
         cnt_ff       <= '0;
         dend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            minus_ff <= minus_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            base_ff  <= base_in;
            cnt_ff   <= cnt_in;
            dend_ff  <= dend_in;
         end
         if (step && emit) begin
            rsp_valid_ff <= 1'b1;
            out_value_ff <= out_value_in;
            out_ovf_ff   <= out_ovf_in;
            out_end_ff   <= out_end_in;
            out_bad_ff   <= out_bad_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign out_end_ext = OB_EXT'(out_end_ff);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = RSP_DATA_W'({out_bad_ff, out_end_ext[END_W-1:0], out_ovf_ff,
                                     VALUE_W'(out_value_ff)});

   a_bad_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_bad_ff) |-> (out_value_ff == '0 && out_end_ff == '0 && !out_ovf_ff))
      else $error("bad radix result carries data");

   a_emit_ends_string: assert property (@(posedge clock) disable iff (reset)
      (step && emit) |=> (phase_ff == PH_DONE))
      else $error("result emitted without ending the string");

   a_ws_state_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WS) |-> (acc_ff == '0 && !ovf_ff && dend_ff == '0 && !minus_ff))
      else $error("accumulator state not clear while skipping whitespace");

   a_end_within_count: assert property (@(posedge clock) disable iff (reset)
      dend_ff <= cnt_ff)
      else $error("digit end beyond characters consumed");

endmodule

[tb/sv/parse_checker.sv]
`timescale 1ns / 1ps

module parse_checker import rit_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [CH_W-1:0]       req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    outstanding
);

   typedef enum logic [2:0] {
      SCAN_WS, SCAN_SIGNED, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS, SCAN_DONE
   } scan_phase_type;

   // declared high field first, so value lands in the low bits as on rsp_tdata
   typedef struct packed {
      logic               bad_radix;
      logic [END_W-1:0]   end_offset;
      logic               overflowed;
      logic [VALUE_W-1:0] value;
   } number_type;

   localparam logic [VALUE_W-1:0] UMAX = '1;
   localparam logic [VALUE_W-1:0] IMAX = UMAX >> 1;
   localparam logic [END_W-1:0]   OFFSET_MAX = '1;

   scan_phase_type     scan;
   logic               negative;
   logic [VALUE_W-1:0] accum;
   logic               saturated;
   logic [RADIX_W-1:0] base;
   logic [END_W-1:0]   consumed;
   logic [END_W-1:0]   last_digit_at;
   logic               finished;
   logic [RADIX_W-1:0] radix_reg;
   logic               signed_reg;

   number_type expected_numbers[$];
   int         reported;

   function automatic int char_digit(logic [CH_W-1:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - CH_LO_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A) + 10;
      return int'(DIGIT_NONE);
   endfunction

   function automatic void count_char();
      if (consumed != OFFSET_MAX) consumed = consumed + 1'b1;
   endfunction

   function automatic bit emit_number(logic [VALUE_W-1:0] v, logic o, logic [END_W-1:0] e,
                                      logic b, output number_type r);
      r.value      = v;
      r.overflowed = o;
      r.end_offset = e;
      r.bad_radix  = b;
      scan         = SCAN_DONE;
      finished     = 1'b1;
      return 1'b1;
   endfunction

   function automatic bit close_number(output number_type r);
      logic [VALUE_W-1:0] v;
      logic               o;
      v = accum;
      o = saturated;
      if (!signed_reg) begin
         if (negative) v = UMAX;
      end else if (negative) begin
         if (v > IMAX + 1'b1) begin
            v = IMAX + 1'b1;
            o = 1'b1;
         end
         v = '0 - v;
      end else if (v > IMAX) begin
         v = IMAX;
         o = 1'b1;
      end
      return emit_number(v, o, last_digit_at, 1'b0, r);
   endfunction

   function automatic bit take_digit(logic [CH_W-1:0] c, output number_type r);
      int                 d;
      logic [VALUE_W-1:0] d64;
      logic [VALUE_W-1:0] b64;
      d = char_digit(c);
      if (base < BASE_MIN || d >= base) return close_number(r);
      d64 = VALUE_W'(d);
      b64 = VALUE_W'(base);
      if (!saturated) begin
         if (accum > (UMAX - d64) / b64) begin
            saturated = 1'b1;
            accum     = UMAX;
         end else begin
            accum = accum * b64 + d64;
         end
      end
      count_char();
      last_digit_at = consumed;
      return 1'b0;
   endfunction

   function automatic bit leading_char(logic [CH_W-1:0] c, output number_type r);
      if (c == CH_0 && (base == BASE_AUTO || base == BASE_HEX)) begin
         count_char();
         last_digit_at = consumed;
         scan = SCAN_ZERO;
         return 1'b0;
      end
      if (base == BASE_AUTO) base = BASE_DEC;
      if (char_digit(c) < base) begin
         scan = SCAN_DIGITS;
         return take_digit(c, r);
      end
      return emit_number('0, 1'b0, '0, 1'b0, r);
   endfunction

   function automatic bit after_zero(logic [CH_W-1:0] c, output number_type r);
      if (c == CH_LO_X || c == CH_UP_X) begin
         count_char();
         base = BASE_HEX;
         scan = SCAN_PREFIX;
         return 1'b0;
      end
      if (base == BASE_AUTO) base = BASE_OCT;
      scan = SCAN_DIGITS;
      return take_digit(c, r);
   endfunction

   function automatic void clear_scan();
      scan          = SCAN_WS;
      negative      = 1'b0;
      accum         = '0;
      saturated     = 1'b0;
      consumed      = '0;
      last_digit_at = '0;
      finished      = 1'b0;
   endfunction

   // one character in, at most one number out
   function automatic bit parse_char(logic [CH_W-1:0] c, logic first, output number_type r);
      if (first) begin
         clear_scan();
         if (radix_reg == BASE_ONE || radix_reg > BASE_MAX)
            return emit_number('0, 1'b0, '0, 1'b1, r);
         base = radix_reg;
      end
      if (finished || scan == SCAN_DONE) return 1'b0;
      case (scan)
         SCAN_WS: begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
               count_char();
               return 1'b0;
            end
            if (c == CH_PLUS || c == CH_MINUS) begin
               negative = (c == CH_MINUS);
               count_char();
               scan = SCAN_SIGNED;
               return 1'b0;
            end
            return leading_char(c, r);
         end
         SCAN_SIGNED: return leading_char(c, r);
         SCAN_ZERO:   return after_zero(c, r);
         SCAN_PREFIX: begin
            if (char_digit(c) < 16) begin
               scan = SCAN_DIGITS;
               return take_digit(c, r);
            end
            return close_number(r);
         end
         default: return take_digit(c, r);
      endcase
   endfunction

   always @(posedge clock) begin
      number_type got;
      number_type want;
      number_type fresh;
      if (reset) begin
         clear_scan();
         base       = BASE_DEC;
         radix_reg  = RADIX_RESET;
         signed_reg = 1'b0;
         expected_numbers.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_RADIX:  radix_reg  = csr_wdata;
               CSR_SIGNED: signed_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = number_type'(rsp_tdata[RSP_RAW_W-1:0]);
            if (expected_numbers.size() == 0) begin
               fail_count++;
               if (reported < 10)
                  $display("unexpected number: value %h ovf %b end %0d bad %b",
                           got.value, got.overflowed, got.end_offset, got.bad_radix);
               reported++;
            end else begin
               want = expected_numbers.pop_front();
               if (got.value !== want.value || got.overflowed !== want.overflowed ||
                   got.end_offset !== want.end_offset || got.bad_radix !== want.bad_radix) begin
                  fail_count++;
                  if (reported < 10)
                     $display("mismatch: exp value %h ovf %b end %0d bad %b / got %h %b %0d %b",
                              want.value, want.overflowed, want.end_offset, want.bad_radix,
                              got.value, got.overflowed, got.end_offset, got.bad_radix);
                  reported++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (parse_char(req_tdata, req_tuser, fresh)) expected_numbers.push_back(fresh);
         end
      end
      outstanding = expected_numbers.size();
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import rit_pkg::*;

   localparam int ITEM_TARGET = 1300;
   localparam int QUIET_LIMIT = 4000;
   localparam int SETTLE      = 8;
   localparam int LONG_RUN    = 40;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic [CH_W-1:0]       req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int  fail_count;
   int  outstanding;
   int  items_sent   = 0;
   int  stall_left   = 0;
   int  quiet_cycles = 0;
   bit  req_idle_en  = 1'b0;
   bit  rsp_stall_en = 1'b0;

   logic [CH_W-1:0] text_q[$];

   string boundary_text [6] = '{
      "18446744073709551615", "18446744073709551616", "9223372036854775807",
      "9223372036854775808", "9223372036854775809", "99999999999999999999"
   };

   radix_integer_text_parser dut (.*);

   parse_checker number_check (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (rsp_stall_en && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 19) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   function automatic logic [CH_W-1:0] digit_char(int d);
      if (d < 10) return CH_0 + CH_W'(d);
      return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + CH_W'(d - 10);
   endfunction

   function automatic logic [CH_W-1:0] space_char();
      return $urandom_range(0, 1) ? CH_SPACE : CH_W'($urandom_range(CH_TAB, CH_CR));
   endfunction

   function automatic logic [CH_W-1:0] x_char();
      return $urandom_range(0, 1) ? CH_LO_X : CH_UP_X;
   endfunction

   // never a digit in base eff
   function automatic logic [CH_W-1:0] end_char(int eff);
      case ($urandom_range(0, 7))
         0, 1, 2: return 8'h00;
         3:       return CH_SPACE;
         4:       return 8'h80 | CH_W'($urandom_range(0, 127));
         5:       return (eff < 36) ? digit_char($urandom_range(eff, 35)) : ".";
         6:       return $urandom_range(0, 1) ? CH_MINUS : "_";
         default: return ".";
      endcase
   endfunction

   function automatic int digit_count();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return 0;
      if (sel <= 11) return $urandom_range(1, 6);
      if (sel <= 15) return $urandom_range(7, 20);
      if (sel <= 18) return $urandom_range(21, 70);
      return $urandom_range(60, 70);
   endfunction

   task automatic push_char(input logic [CH_W-1:0] c, input bit first);
      if (req_idle_en && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_text(input bit mark_first);
      foreach (text_q[i]) push_char(text_q[i], mark_first && i == 0);
   endtask

   task automatic say(input string s, input bit with_nul, input bit mark_first);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      if (with_nul) text_q.push_back(8'h00);
      send_text(mark_first);
   endtask

   // registers change only once the parser has drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input int radix, input bit sgn);
      write_reg(CSR_RADIX, CSR_DATA_W'(radix));
      write_reg(CSR_SIGNED, CSR_DATA_W'(sgn));
   endtask

   task automatic build_number(input int radix);
      string s;
      int    eff;
      int    n;
      text_q.delete();
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(space_char());
      case ($urandom_range(0, 3))
         1: text_q.push_back(CH_PLUS);
         2: text_q.push_back(CH_MINUS);
         default: ;
      endcase
      eff = radix;
      if (radix == BASE_AUTO) begin
         case ($urandom_range(0, 2))
            0: begin
               text_q.push_back(CH_0);
               text_q.push_back(x_char());
               eff = BASE_HEX;
            end
            1: begin
               text_q.push_back(CH_0);
               eff = BASE_OCT;
            end
            default: begin
               text_q.push_back(digit_char($urandom_range(1, 9)));
               eff = BASE_DEC;
            end
         endcase
      end else if (radix == BASE_HEX && $urandom_range(0, 1)) begin
         text_q.push_back(CH_0);
         text_q.push_back(x_char());
      end
      n = digit_count();
      if (eff == BASE_DEC && $urandom_range(0, 7) == 0) begin
         s = boundary_text[$urandom_range(0, 5)];
         for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      end else if ($urandom_range(0, 9) == 0) begin
         repeat (n) text_q.push_back(digit_char(eff - 1));
      end else begin
         repeat (n) text_q.push_back(digit_char($urandom_range(0, eff - 1)));
      end
      text_q.push_back(end_char(eff));
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) text_q.push_back(CH_W'($urandom_range(0, 255)));
   endtask

   // malformed or cut-off strings
   task automatic build_noise();
      text_q.delete();
      case ($urandom_range(0, 5))
         0: begin
            repeat ($urandom_range(1, 10)) text_q.push_back(CH_W'($urandom_range(0, 255)));
            text_q.push_back(8'h00);
         end
         1: begin
            text_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            text_q.push_back(end_char(36));
         end
         2: begin
            text_q.push_back(CH_0);
            text_q.push_back(x_char());
            text_q.push_back($urandom_range(0, 1) ? digit_char($urandom_range(16, 35)) : 8'h00);
         end
         3: repeat ($urandom_range(1, 5)) text_q.push_back(digit_char($urandom_range(0, 9)));
         4: begin
            repeat ($urandom_range(1, 4)) text_q.push_back(space_char());
            text_q.push_back(8'h00);
         end
         default: begin
            text_q.push_back(CH_PLUS);
            text_q.push_back(CH_MINUS);
            text_q.push_back(CH_0 + 8'd5);
            text_q.push_back(8'h00);
         end
      endcase
   endtask

   initial begin
      int radix;
      bit sgn;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed: no leading first, minus in unsigned mode, empty sign
      say("7", 1'b1, 1'b0);
      say(" -12.", 1'b0, 1'b1);
      say("+x", 1'b0, 1'b1);
      set_config(BASE_HEX, 1'b0);
      say("0xg", 1'b0, 1'b1);
      say("0XfF", 1'b1, 1'b1);
      set_config(BASE_AUTO, 1'b1);
      say("017", 1'b1, 1'b1);
      set_config(BASE_ONE, 1'b1);
      say("5", 1'b0, 1'b1);
      set_config(63, 1'b0);
      say("5", 1'b0, 1'b1);
      set_config(BASE_MAX, 1'b1);
      say("zZ", 1'b1, 1'b1);

      // long whitespace run, then digits that continue the same string
      for (int i = 0; i < LONG_RUN; i++) push_char(CH_SPACE, i == 0);
      say("12", 1'b1, 1'b0);

      items_sent = 0;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 11))
            0, 1:    radix = BASE_AUTO;
            2:       radix = BASE_MIN;
            3:       radix = BASE_MAX;
            4:       radix = BASE_OCT;
            5:       radix = BASE_HEX;
            6, 7:    radix = BASE_DEC;
            8:       radix = $urandom_range(0, 1) ? BASE_ONE : $urandom_range(37, 63);
            default: radix = $urandom_range(2, 36);
         endcase
         sgn = $urandom_range(0, 1);
         set_config(radix, sgn);
         req_idle_en  = $urandom_range(0, 2) != 0;
         rsp_stall_en = $urandom_range(0, 2) != 0;
         repeat ($urandom_range(8, 30)) begin
            if (items_sent < ITEM_TARGET) begin
               if (items_sent > ITEM_TARGET * 85 / 100) begin
                  req_idle_en  = 1'b0;
                  rsp_stall_en = 1'b0;
               end
               if (radix == BASE_ONE || radix > BASE_MAX) begin
                  text_q.delete();
                  repeat ($urandom_range(1, 4)) text_q.push_back(CH_W'($urandom_range(0, 255)));
               end else if ($urandom_range(0, 4) == 0) begin
                  build_noise();
               end else begin
                  build_number(radix);
               end
               send_text(1'b1);
            end
         end
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
